### rtl/core/kfli_pkg.sv
// Shared types, codes and default sizes of the keyframe linear interpolator.
`default_nettype none

package kfli_pkg;

	localparam int MAX_KEYS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TIME_W        = 32;
	localparam int POS_W         = 18;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
	} key_t;

endpackage

`default_nettype wire

### rtl/core/kfli_div.sv
// Radix-2 restoring divider that produces the interpolation fraction.
`default_nettype none

module kfli_div #(
	parameter int FRAC_BITS = kfli_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [kfli_pkg::TIME_W-1:0]        num,
	input  wire logic [kfli_pkg::TIME_W-1:0]        den,
	output logic                                    done,
	output logic [FRAC_BITS:0]                      quo
);

	localparam int QW = FRAC_BITS + 1;
	localparam int SW = $clog2(QW + 1);
	localparam int TW = kfli_pkg::TIME_W;

	logic          busy_q;
	logic [SW-1:0] cnt_q;
	logic [TW:0]   rem_q;
	logic [TW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic          ge;
	logic [TW:0]   nr;

	assign ge   = rem_q >= {1'b0, den_q};
	assign nr   = ge ? (rem_q - {1'b0, den_q}) : rem_q;
	assign done = busy_q && (cnt_q == SW'(1));
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= SW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - SW'(1);
			if (cnt_q == SW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {nr[TW-1:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

### rtl/core/keyframe_linear_interpolator_unit.sv
// Top level: keyframe table in synchronous memory, scan, divide and interpolate.
// Clear, append and unknown ops give no word; one query is in flight at a time.
// An empty query or one that clamps to an end keyframe skips scan and divide and goes to ST_OUT.
// An inner query scans from entry 0 to the first entry whose stamp reaches the query time,
// divides, then scales and adds x and y in ST_MX, ST_MY and ST_FIN; out_ready can stall the word.
// Reset empties the table and drops any pending word; memory contents need no reset.
`default_nettype none

module keyframe_linear_interpolator_unit #(
	parameter int MAX_KEYS  = kfli_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kfli_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          op,
	input  wire logic [kfli_pkg::TIME_W-1:0]         stamp_ms,
	input  wire logic signed [kfli_pkg::POS_W-1:0]   pos_x,
	input  wire logic signed [kfli_pkg::POS_W-1:0]   pos_y,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     found,
	output logic signed [kfli_pkg::POS_W-1:0]        out_x,
	output logic signed [kfli_pkg::POS_W-1:0]        out_y
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int PSW = kfli_pkg::POS_W;
	localparam int QW = FRAC_BITS + 1;
	localparam int DW = PSW + 1;
	localparam int PW = DW + QW + 1;
	localparam logic [CW-1:0] FULL = CW'(MAX_KEYS);
	localparam logic [PW-1:0] BIAS = (PW'(1) << FRAC_BITS) - PW'(1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MX   = 3'd3;
	localparam logic [2:0] ST_MY   = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	kfli_pkg::key_t          first_q;
	kfli_pkg::key_t          last_q;
	kfli_pkg::key_t          mem [MAX_KEYS];
	kfli_pkg::key_t          rd_data_s1;
	kfli_pkg::key_t          prev_q;
	kfli_pkg::key_t          next_q;
	kfli_pkg::key_t          new_key;
	logic [AW-1:0]           rd_addr_q;
	logic                    rd_vld_q;
	logic [kfli_pkg::TIME_W-1:0] t_q;

	logic                    accept;
	logic                    append_ok;
	logic                    hit;
	logic                    div_start;
	logic                    div_done;
	logic [QW-1:0]           quo;
	logic                    out_free;

	logic signed [DW-1:0]    mul_a;
	logic signed [QW:0]      frac_s;
	logic signed [PW-1:0]    mul_w;
	logic signed [PW-1:0]    prod_s1;
	logic [PW-1:0]           inc_w;
	logic [PSW-1:0]          inc;

	logic                    res_found_q;
	logic [PSW-1:0]          res_x_q;
	logic [PSW-1:0]          res_y_q;
	logic                    out_valid_q;
	logic                    found_q;
	logic [PSW-1:0]          out_x_q;
	logic [PSW-1:0]          out_y_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign new_key   = '{stamp: stamp_ms, x: pos_x, y: pos_y};
	assign append_ok = (count_q != FULL) &&
		((count_q == '0) || (stamp_ms >= last_q.stamp));
	assign hit       = (state_q == ST_SCAN) && rd_vld_q && (t_q <= rd_data_s1.stamp);
	assign div_start = hit;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;

	kfli_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - prev_q.stamp),
		.den    (rd_data_s1.stamp - prev_q.stamp),
		.done   (div_done),
		.quo    (quo)
	);

	// keyframe memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && (op == kfli_pkg::OP_APPEND) && append_ok) begin
			mem[count_q[AW-1:0]] <= new_key;
		end
		rd_data_s1 <= mem[rd_addr_q];
	end

	always_comb begin
		if (state_q == ST_MX) begin
			mul_a = $signed({next_q.x[PSW-1], next_q.x}) - $signed({prev_q.x[PSW-1], prev_q.x});
		end else begin
			mul_a = $signed({next_q.y[PSW-1], next_q.y}) - $signed({prev_q.y[PSW-1], prev_q.y});
		end
		frac_s = $signed({1'b0, quo});
		mul_w  = mul_a * frac_s;
		inc_w  = PW'($signed(prod_s1 + (prod_s1[PW-1] ? BIAS : '0)) >>> FRAC_BITS);
		inc    = inc_w[PSW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_vld_q <= 1'b0;
					if (accept) begin
						case (op)
							kfli_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							kfli_pkg::OP_APPEND: begin
								if (append_ok) begin
									count_q <= count_q + CW'(1);
								end
							end
							kfli_pkg::OP_QUERY: begin
								if (count_q == '0 || stamp_ms <= first_q.stamp ||
									stamp_ms >= last_q.stamp) begin
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_q <= 1'b1;
					if (hit) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MX;
					end
				end
				ST_MX:  state_q <= ST_MY;
				ST_MY:  state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op == kfli_pkg::OP_APPEND) && append_ok) begin
			last_q <= new_key;
			if (count_q == '0) begin
				first_q <= new_key;
			end
		end
		if (accept && (op == kfli_pkg::OP_QUERY)) begin
			t_q       <= stamp_ms;
			rd_addr_q <= '0;
			if (count_q == '0) begin
				res_found_q <= 1'b0;
				res_x_q     <= '0;
				res_y_q     <= '0;
			end else if (stamp_ms <= first_q.stamp) begin
				res_found_q <= 1'b1;
				res_x_q     <= first_q.x;
				res_y_q     <= first_q.y;
			end else begin
				res_found_q <= 1'b1;
				res_x_q     <= last_q.x;
				res_y_q     <= last_q.y;
			end
		end
		if (state_q == ST_SCAN) begin
			rd_addr_q <= rd_addr_q + AW'(1);
			if (rd_vld_q) begin
				if (hit) begin
					next_q <= rd_data_s1;
				end else begin
					prev_q <= rd_data_s1;
				end
			end
		end
		if (state_q == ST_MX || state_q == ST_MY) begin
			prod_s1 <= mul_w;
		end
		if (state_q == ST_MY) begin
			res_x_q <= prev_q.x + inc;
		end
		if (state_q == ST_FIN) begin
			res_y_q     <= prev_q.y + inc;
			res_found_q <= 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			found_q <= res_found_q;
			out_x_q <= res_x_q;
			out_y_q <= res_y_q;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("key count beyond table size");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == kfli_pkg::OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the table");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (rd_data_s1.stamp != prev_q.stamp))
		else $error("divider started with zero span");

	a_word_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result word not presented");
`endif

endmodule

`default_nettype wire

### tb/kfli_checker.sv
// Checker for the keyframe interpolator: tracks the keyframe table, predicts query positions, compares result words.
`timescale 1ns / 1ps

module kfli_checker #(
	parameter int MAX_KEYS  = kfli_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = kfli_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [1:0]                          op,
	input  logic [kfli_pkg::TIME_W-1:0]         stamp_ms,
	input  logic signed [kfli_pkg::POS_W-1:0]   pos_x,
	input  logic signed [kfli_pkg::POS_W-1:0]   pos_y,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                found,
	input  logic signed [kfli_pkg::POS_W-1:0]   out_x,
	input  logic signed [kfli_pkg::POS_W-1:0]   out_y,
	output int                                  fail_count,
	output int                                  waiting
);

	localparam int TW = kfli_pkg::TIME_W;
	localparam int PW = kfli_pkg::POS_W;

	typedef struct packed {
		logic          found;
		logic [PW-1:0] x;
		logic [PW-1:0] y;
	} pos_word_t;

	logic [TW-1:0]        key_stamp [MAX_KEYS];
	logic signed [PW-1:0] key_px    [MAX_KEYS];
	logic signed [PW-1:0] key_py    [MAX_KEYS];
	int                   key_n = 0;
	int                   errs = 0;
	pos_word_t            pos_due [$];
	pos_word_t            want;

	function automatic logic [PW-1:0] blend_coord(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b, input longint frac);
		longint d;
		longint step;
		longint sum;
		d = longint'(b) - longint'(a);
		step = (d * frac) / (longint'(1) << FRAC_BITS);
		sum = longint'(a) + step;
		return sum[PW-1:0];
	endfunction

	function automatic pos_word_t interp_at(input logic [TW-1:0] t);
		pos_word_t r;
		int hit;
		logic [63:0] num;
		logic [63:0] span;
		longint frac;
		r = '0;
		if (key_n == 0)
			return r;
		r.found = 1'b1;
		if (t <= key_stamp[0]) begin
			r.x = key_px[0];
			r.y = key_py[0];
		end else if (t >= key_stamp[key_n-1]) begin
			r.x = key_px[key_n-1];
			r.y = key_py[key_n-1];
		end else begin
			hit = 1;
			while (t > key_stamp[hit])
				hit++;
			frac = 0;
			if (key_stamp[hit] > key_stamp[hit-1]) begin
				num = {32'd0, t - key_stamp[hit-1]} << FRAC_BITS;
				span = {32'd0, key_stamp[hit] - key_stamp[hit-1]};
				frac = longint'(num / span);
			end
			r.x = blend_coord(key_px[hit-1], key_px[hit], frac);
			r.y = blend_coord(key_py[hit-1], key_py[hit], frac);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			key_n = 0;
			pos_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				case (op)
					kfli_pkg::OP_CLEAR: key_n = 0;
					kfli_pkg::OP_APPEND: begin
						if (key_n < MAX_KEYS && (key_n == 0 || stamp_ms >= key_stamp[key_n-1])) begin
							key_stamp[key_n] = stamp_ms;
							key_px[key_n] = pos_x;
							key_py[key_n] = pos_y;
							key_n++;
						end
					end
					kfli_pkg::OP_QUERY: pos_due = {pos_due, interp_at(stamp_ms)};
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pos_due.size() == 0) begin
					$error("result word with none expected: found=%0d out_x=%0d out_y=%0d",
						found, out_x, out_y);
					errs++;
				end else begin
					want = pos_due.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, found);
						errs++;
					end
					if (out_x !== want.x) begin
						$error("out_x: expected %0d, actual %0d", $signed(want.x), out_x);
						errs++;
					end
					if (out_y !== want.y) begin
						$error("out_y: expected %0d, actual %0d", $signed(want.y), out_y);
						errs++;
					end
				end
			end
		end
		fail_count <= errs;
		waiting <= pos_due.size();
	end

endmodule

### tb/keyframe_linear_interpolator_unit_tb.sv
// Testbench top for the keyframe interpolator: clock, reset, word stimulus, random stalls and verdict.
`timescale 1ns / 1ps

module keyframe_linear_interpolator_unit_tb;

	localparam int MAX_KEYS    = kfli_pkg::MAX_KEYS_DEF;
	localparam int FRAC_BITS   = kfli_pkg::FRAC_BITS_DEF;
	localparam int PW          = kfli_pkg::POS_W;
	localparam int TW          = kfli_pkg::TIME_W;
	localparam int WORD_TARGET = 1500;
	localparam int CYCLE_LIMIT = 2000000;

	localparam logic [1:0]    OP_NONE = 2'd3;
	localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
	localparam logic [TW-1:0] T_MAX   = {TW{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           op = kfli_pkg::OP_CLEAR;
	logic [TW-1:0]        stamp_ms = '0;
	logic signed [PW-1:0] pos_x = '0;
	logic signed [PW-1:0] pos_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 found;
	logic signed [PW-1:0] out_x;
	logic signed [PW-1:0] out_y;

	int fail_count;
	int waiting;
	int cycles = 0;
	int words_sent = 0;
	bit calm = 1'b0;
	int ready_left = 0;
	bit ready_level = 1'b0;

	logic [TW-1:0] sh_times [MAX_KEYS];
	int            sh_count = 0;
	logic [PW-1:0] last_x = '0;
	logic [PW-1:0] last_y = '0;

	keyframe_linear_interpolator_unit #(
		.MAX_KEYS(MAX_KEYS),
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.stamp_ms(stamp_ms),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.out_x(out_x),
		.out_y(out_y)
	);

	kfli_checker #(
		.MAX_KEYS(MAX_KEYS),
		.FRAC_BITS(FRAC_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.stamp_ms(stamp_ms),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.out_x(out_x),
		.out_y(out_y),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("keyframe_linear_interpolator_unit_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (ready_left == 0) begin
			if (calm) begin
				ready_level = 1'b1;
				ready_left = 1;
			end else if (!ready_level) begin
				ready_level = 1'b1;
				ready_left = $urandom_range(1, 24);
			end else begin
				ready_level = 1'b0;
				if ($urandom_range(0, 99) < 75)
					ready_left = $urandom_range(1, 2);
				else if ($urandom_range(0, 99) < 80)
					ready_left = $urandom_range(3, 10);
				else
					ready_left = $urandom_range(20, 80);
			end
		end
		ready_left--;
		out_ready <= ready_level;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PW-1:0] rand_pos();
		int r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = $urandom();
		if (r < 8)
			return POS_MAX;
		if (r < 16)
			return POS_MIN;
		if (r < 22)
			return '0;
		return v[PW-1:0];
	endfunction

	function automatic logic [TW-1:0] pick_query_time();
		int r;
		logic [TW-1:0] lo;
		logic [TW-1:0] hi;
		if (sh_count == 0)
			return $urandom();
		lo = sh_times[0];
		hi = sh_times[sh_count-1];
		r = $urandom_range(0, 99);
		if (r < 35)
			return lo + $urandom_range(0, hi - lo);
		if (r < 55)
			return sh_times[$urandom_range(0, sh_count - 1)];
		if (r < 65)
			return sh_times[$urandom_range(0, sh_count - 1)] + (r[0] ? 32'd1 : T_MAX);
		if (r < 75)
			return $urandom_range(0, lo);
		if (r < 85)
			return $urandom_range(hi, T_MAX);
		return $urandom();
	endfunction

	task automatic send_word(input logic [1:0] o, input logic [TW-1:0] s,
			input logic [PW-1:0] x, input logic [PW-1:0] y);
		int gap;
		in_valid <= 1'b1;
		op <= o;
		stamp_ms <= s;
		pos_x <= x;
		pos_y <= y;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_key(input logic [TW-1:0] s, input logic [PW-1:0] x,
			input logic [PW-1:0] y);
		if (sh_count < MAX_KEYS && (sh_count == 0 || s >= sh_times[sh_count-1])) begin
			sh_times[sh_count] = s;
			sh_count++;
			last_x = x;
			last_y = y;
			words_sent++;
		end
		send_word(kfli_pkg::OP_APPEND, s, x, y);
	endtask

	task automatic ask(input logic [TW-1:0] t);
		words_sent++;
		send_word(kfli_pkg::OP_QUERY, t, rand_pos(), rand_pos());
	endtask

	task automatic wipe();
		sh_count = 0;
		words_sent++;
		send_word(kfli_pkg::OP_CLEAR, $urandom(), rand_pos(), rand_pos());
	endtask

	task automatic stray_word();
		logic [TW-1:0] prev;
		if (sh_count > 0 && sh_times[sh_count-1] > 0 && $urandom_range(0, 1) == 1) begin
			prev = sh_times[sh_count-1];
			send_word(kfli_pkg::OP_APPEND, $urandom_range(0, prev - 1), rand_pos(), rand_pos());
		end else begin
			send_word(OP_NONE, $urandom(), rand_pos(), rand_pos());
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	task automatic play_sequence(input bit fill);
		int nk;
		int nq;
		int r;
		int tmp;
		longint nx;
		logic [TW-1:0] s;
		logic [PW-1:0] px;
		logic [PW-1:0] py;
		calm = ($urandom_range(0, 99) < 12);
		if (fill || $urandom_range(0, 99) < 85)
			wipe();
		r = $urandom_range(0, 99);
		if (fill)
			nk = MAX_KEYS + 6;
		else if (r < 8)
			nk = $urandom_range(MAX_KEYS - 4, MAX_KEYS + 6);
		else if (r < 18)
			nk = 0;
		else
			nk = $urandom_range(1, 8);
		for (int k = 0; k < nk; k++) begin
			if ($urandom_range(0, 99) < 6)
				stray_word();
			if (sh_count == 0) begin
				s = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 2000);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15)
					nx = 0;
				else if (r < 65)
					nx = $urandom_range(1, 100);
				else if (r < 90)
					nx = $urandom_range(101, 100000);
				else
					nx = $urandom_range(100001, 32'h0FFF_FFFF);
				nx = nx + longint'(sh_times[sh_count-1]);
				if (nx > longint'(T_MAX))
					nx = longint'(T_MAX);
				s = nx[TW-1:0];
			end
			if (sh_count > 0 && $urandom_range(0, 99) < 25) begin
				tmp = int'($signed(last_x)) + $urandom_range(0, 64) - 32;
				px = tmp[PW-1:0];
				tmp = int'($signed(last_y)) + $urandom_range(0, 64) - 32;
				py = tmp[PW-1:0];
			end else begin
				px = rand_pos();
				py = rand_pos();
			end
			put_key(s, px, py);
		end
		nq = $urandom_range(3, 12);
		for (int q = 0; q < nq; q++) begin
			if ($urandom_range(0, 99) < 5)
				stray_word();
			ask(pick_query_time());
		end
		if ($urandom_range(0, 99) < 4)
			hold_until_drained();
		calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ask('0);
		ask(T_MAX);
		send_word(OP_NONE, T_MAX, POS_MAX, POS_MIN);
		put_key(32'd100, POS_MAX, POS_MIN);
		ask(32'd50);
		ask(32'd100);
		put_key(32'd100, POS_MIN, POS_MAX);
		put_key(32'd50, POS_MAX, POS_MAX);
		put_key(32'd1100, '0, '0);
		put_key(T_MAX, 18'd1, POS_MAX ^ POS_MIN);
		ask(32'd100);
		ask(32'd101);
		ask(32'd600);
		ask(32'd1100);
		ask(32'd1101);
		ask(T_MAX - 32'd1);
		ask(T_MAX);
		send_word(OP_NONE, '0, '0, '0);
		wipe();
		ask(32'd500);
		put_key('0, POS_MIN, POS_MAX);
		ask('0);
		ask(T_MAX);
		hold_until_drained();

		words_sent = 0;
		play_sequence(1'b1);
		while (words_sent < WORD_TARGET)
			play_sequence(1'b0);

		hold_until_drained();
		repeat (MAX_KEYS + FRAC_BITS + 12) @(posedge clk);
		if (fail_count == 0)
			$display("keyframe_linear_interpolator_unit_tb: PASS");
		else
			$display("keyframe_linear_interpolator_unit_tb: FAIL");
		$finish;
	end

endmodule
